FILE: rtl/lfi_pkg.sv
package lfi_pkg;

	localparam int PORTS_DEF = 4;
	localparam int PORT_W    = 2;
	localparam int CMD_W     = 2;
	localparam int BYTE_W    = 8;
	localparam int CNT_W     = 32;
	localparam int PCT_W     = 7;
	localparam int DLY_W     = 13;
	localparam int MASK_W    = 4;
	localparam int DROP_TBL_W  = 28;
	localparam int CORR_TBL_W  = 28;
	localparam int DLY_TBL_W   = 52;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 52;

	// request codes
	localparam logic [CMD_W-1:0] CMD_TX    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RX    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_PCT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CORR_PCT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 2'd3;

	// hash v = count*MUL + OFS, kept incrementally along with its mod-100 residue
	localparam int MOD  = 100;
	localparam int MUL  = 37;
	localparam int OFS  = 17;
	localparam logic [BYTE_W-1:0] CORRUPT_XOR = 8'h5A;
	localparam longint WRAP_RES = (64'd1 << CNT_W) % MOD;           // 2^32 mod 100
	localparam logic [PCT_W-1:0] CNT_STEP      = PCT_W'(1);
	localparam logic [PCT_W-1:0] CNT_STEP_WRAP = PCT_W'((1 + MOD - WRAP_RES) % MOD);
	localparam logic [PCT_W-1:0] V_STEP        = PCT_W'(MUL % MOD);
	localparam logic [PCT_W-1:0] V_STEP_WRAP   = PCT_W'((MUL + MOD - WRAP_RES) % MOD);

	typedef struct packed {
		logic [CNT_W-1:0] frame;
		logic [CNT_W-1:0] drop;
		logic [CNT_W-1:0] rxdrop;
		logic [CNT_W-1:0] corrupt;
		logic [CNT_W-1:0] delay;
		logic [CNT_W-1:0] hash;      // count*37+17 mod 2^32
		logic [PCT_W-1:0] cnt_res;   // count mod 100
		logic [PCT_W-1:0] hash_res;  // hash mod 100
	} port_state_t;

	localparam port_state_t ST_RESET = '{
		frame:    '0,
		drop:     '0,
		rxdrop:   '0,
		corrupt:  '0,
		delay:    '0,
		hash:     CNT_W'(OFS),
		cnt_res:  '0,
		hash_res: PCT_W'(OFS)
	};

	// residue add, both operands below MOD
	function automatic logic [PCT_W-1:0] mod_add(input logic [PCT_W-1:0] r,
		input logic [PCT_W-1:0] a);
		logic [PCT_W:0] s;
		s = {1'b0, r} + {1'b0, a};
		if (s >= (PCT_W+1)'(MOD)) begin
			s = s - (PCT_W+1)'(MOD);
		end
		return s[PCT_W-1:0];
	endfunction

endpackage

FILE: rtl/link_fault_injector.sv
// link_fault_injector
// Per-port deterministic fault injector. Each request on the input channel
// (cmd, port, last_byte) yields exactly one result on the output channel:
// drop/corrupt/delay decisions, the possibly corrupted last byte and the
// port's five counters after the request.
// Channels: in_valid/in_stall and out_valid/out_stall; a transfer happens on
// a rising edge with valid high and stall low. Configuration writes use
// cfg_valid/cfg_ready (ready is always high), cfg_index selects the register.
// Write registers only while no request is in flight.
// Path: each request passes the input register, then the result register.
// Throughput: one request per cycle while out_stall is low, also back to back
// on the same port; the per-port counter update is a read-modify-write
// between the two registers.
// Mod-100 decisions use residues kept next to each counter, so no divider.
// Stall: while out_stall holds a waiting result, one more request is taken
// into the input register, then in_stall rises.
// Reset (arst_n low): all counters cleared, registers zeroed, both stages
// empty.
module link_fault_injector
	import lfi_pkg::*;
#(
	parameter int PORTS = PORTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [PORT_W-1:0]     port,
	input  logic [BYTE_W-1:0]     last_byte,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  drop_frame,
	output logic                  corrupt_frame,
	output logic                  delay_frame,
	output logic [DLY_W-1:0]      delay_amount,
	output logic [BYTE_W-1:0]     out_byte,
	output logic [CNT_W-1:0]      frames_seen_count,
	output logic [CNT_W-1:0]      dropped_count,
	output logic [CNT_W-1:0]      rx_dropped_count,
	output logic [CNT_W-1:0]      corrupted_count,
	output logic [CNT_W-1:0]      delayed_count,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// config registers
	logic [MASK_W-1:0]     down_mask_q;
	logic [DROP_TBL_W-1:0] drop_tbl_q;
	logic [CORR_TBL_W-1:0] corr_tbl_q;
	logic [DLY_TBL_W-1:0]  dly_tbl_q;

	// input stage
	logic                  valid_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [PORT_W-1:0]     port_s1;
	logic [BYTE_W-1:0]     byte_s1;

	// result stage
	logic                  valid_s2;
	logic                  drop_s2;
	logic                  corrupt_s2;
	logic                  delay_s2;
	logic [DLY_W-1:0]      amount_s2;
	logic [BYTE_W-1:0]     byte_s2;
	logic [CNT_W-1:0]      frame_cnt_s2;
	logic [CNT_W-1:0]      drop_cnt_s2;
	logic [CNT_W-1:0]      rxdrop_cnt_s2;
	logic [CNT_W-1:0]      corr_cnt_s2;
	logic [CNT_W-1:0]      delay_cnt_s2;

	port_state_t st_q [PORTS];

	logic          advance;
	logic          fire;
	port_state_t   sel;
	port_state_t   nxt;
	logic          down;
	logic [PCT_W-1:0] dpct;
	logic [PCT_W-1:0] cpct;
	logic [DLY_W-1:0] dly;
	logic          port_ok;
	logic [CNT_W:0] frame_inc;
	logic [CNT_W:0] hash_inc;
	logic          r_drop;
	logic          r_corrupt;
	logic          r_delay;
	logic [DLY_W-1:0]  r_amount;
	logic [BYTE_W-1:0] r_byte;

	assign cfg_ready = 1'b1;

	// result register frees when empty or being taken
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_mask_q <= '0;
			drop_tbl_q  <= '0;
			corr_tbl_q  <= '0;
			dly_tbl_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DOWN_MASK: down_mask_q <= cfg_data[MASK_W-1:0];
				REG_DROP_PCT:  drop_tbl_q  <= cfg_data[DROP_TBL_W-1:0];
				REG_CORR_PCT:  corr_tbl_q  <= cfg_data[CORR_TBL_W-1:0];
				REG_DELAY:     dly_tbl_q   <= cfg_data[DLY_TBL_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd;
			port_s1 <= port;
			byte_s1 <= last_byte;
		end
	end

	// pick the addressed port's state and settings
	always_comb begin
		sel  = '0;
		down = 1'b0;
		dpct = '0;
		cpct = '0;
		dly  = '0;
		for (int i = 0; i < PORTS; i++) begin
			if (port_s1 == PORT_W'(i)) begin
				sel  = st_q[i];
				down = down_mask_q[i];
				dpct = drop_tbl_q[PCT_W*i +: PCT_W];
				cpct = corr_tbl_q[PCT_W*i +: PCT_W];
				dly  = dly_tbl_q[DLY_W*i +: DLY_W];
			end
		end
	end

	assign port_ok   = {1'b0, port_s1} < (PORT_W+1)'(PORTS);
	assign frame_inc = {1'b0, sel.frame} + (CNT_W+1)'(1);
	assign hash_inc  = {1'b0, sel.hash} + (CNT_W+1)'(MUL);

	// decision and counter update
	always_comb begin
		nxt       = sel;
		r_drop    = 1'b0;
		r_corrupt = 1'b0;
		r_delay   = 1'b0;
		r_amount  = '0;
		r_byte    = '0;
		if (cmd_s1 == CMD_TX) begin
			nxt.frame    = frame_inc[CNT_W-1:0];
			nxt.cnt_res  = mod_add(sel.cnt_res,
				frame_inc[CNT_W] ? CNT_STEP_WRAP : CNT_STEP);
			nxt.hash     = hash_inc[CNT_W-1:0];
			nxt.hash_res = mod_add(sel.hash_res,
				hash_inc[CNT_W] ? V_STEP_WRAP : V_STEP);
			r_byte = byte_s1;
			if (down || nxt.cnt_res < dpct) begin
				r_drop   = 1'b1;
				nxt.drop = sel.drop + CNT_W'(1);
			end else if (nxt.hash_res < cpct) begin
				r_corrupt   = 1'b1;
				nxt.corrupt = sel.corrupt + CNT_W'(1);
				r_byte      = byte_s1 ^ CORRUPT_XOR;
			end
			if (dly != '0 && !r_drop) begin
				r_delay   = 1'b1;
				r_amount  = dly;
				nxt.delay = sel.delay + CNT_W'(1);
			end
		end else if (cmd_s1 == CMD_RX) begin
			if (down) begin
				r_drop     = 1'b1;
				nxt.rxdrop = sel.rxdrop + CNT_W'(1);
			end
		end
	end

	// per-port state; out-of-range ports match no entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORTS; i++) begin
				st_q[i] <= ST_RESET;
			end
		end else if (fire) begin
			for (int i = 0; i < PORTS; i++) begin
				if (cmd_s1 == CMD_CLEAR) begin
					st_q[i] <= ST_RESET;
				end else if (port_s1 == PORT_W'(i)) begin
					st_q[i] <= nxt;
				end
			end
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (cmd_s1 == CMD_CLEAR || !port_ok) begin
				drop_s2       <= 1'b0;
				corrupt_s2    <= 1'b0;
				delay_s2      <= 1'b0;
				amount_s2     <= '0;
				byte_s2       <= '0;
				frame_cnt_s2  <= '0;
				drop_cnt_s2   <= '0;
				rxdrop_cnt_s2 <= '0;
				corr_cnt_s2   <= '0;
				delay_cnt_s2  <= '0;
			end else begin
				drop_s2       <= r_drop;
				corrupt_s2    <= r_corrupt;
				delay_s2      <= r_delay;
				amount_s2     <= r_amount;
				byte_s2       <= r_byte;
				frame_cnt_s2  <= nxt.frame;
				drop_cnt_s2   <= nxt.drop;
				rxdrop_cnt_s2 <= nxt.rxdrop;
				corr_cnt_s2   <= nxt.corrupt;
				delay_cnt_s2  <= nxt.delay;
			end
		end
	end

	assign out_valid         = valid_s2;
	assign drop_frame        = drop_s2;
	assign corrupt_frame     = corrupt_s2;
	assign delay_frame       = delay_s2;
	assign delay_amount      = amount_s2;
	assign out_byte          = byte_s2;
	assign frames_seen_count = frame_cnt_s2;
	assign dropped_count     = drop_cnt_s2;
	assign rx_dropped_count  = rxdrop_cnt_s2;
	assign corrupted_count   = corr_cnt_s2;
	assign delayed_count     = delay_cnt_s2;

endmodule

FILE: rtl/lfi_checker.sv
module link_fault_injector_props
	import lfi_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [CMD_W-1:0]      cmd,
	input logic [PORT_W-1:0]     port,
	input logic [BYTE_W-1:0]     last_byte,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  drop_frame,
	input logic                  corrupt_frame,
	input logic                  delay_frame,
	input logic [DLY_W-1:0]      delay_amount,
	input logic [BYTE_W-1:0]     out_byte,
	input logic [CNT_W-1:0]      frames_seen_count,
	input logic [CNT_W-1:0]      dropped_count,
	input logic [CNT_W-1:0]      rx_dropped_count,
	input logic [CNT_W-1:0]      corrupted_count,
	input logic [CNT_W-1:0]      delayed_count,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
			&& $stable(frames_seen_count) && $stable(drop_frame))
		else $error("result changed while stalled");

	// a dropped frame is neither corrupted nor delayed
	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drop_frame |-> !corrupt_frame && !delay_frame)
		else $error("drop together with corrupt or delay");

	// delay flag and amount agree
	a_delay_amt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (delay_frame == (delay_amount != '0)))
		else $error("delay flag and amount disagree");

	// with nothing buffered, the block cannot stall its input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result stage");

endmodule

bind link_fault_injector link_fault_injector_props u_lfi_props (.*);
